[rtl/rbd_pkg.sv]
// Shared types, codes and constant tables for the rotary encoder and button decoder.
package rbd_pkg;

  // Field and register widths
  localparam int ACTION_W    = 2;
  localparam int EVENT_W     = 3;
  localparam int STEP_W      = 15;
  localparam int PERIOD_W    = 7;
  localparam int COUNT_W     = 16;
  localparam int SPEED_W     = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int ELAPSED_W   = COUNT_W + PERIOD_W;

  // Step table
  localparam int STEP_TABLE_DEPTH_DEF = 30;
  localparam int STEP_IDX_W           = 5;

  // Speed computation: floor(DIV_NUM / elapsed), clamped to 1..SPEED_MAX
  localparam int DIV_NUM_W = 10;
  localparam logic [DIV_NUM_W-1:0] DIV_NUM = 10'd1000;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 5'd30;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 5'd1;

  // Detent patterns of the transition history
  localparam logic [7:0] HIST_CW  = 8'h2b;
  localparam logic [7:0] HIST_CCW = 8'h17;

  // Bit i is set when transition code i is a legal quadrature move
  localparam logic [15:0] VALID_MOVE = 16'b0110_1001_1001_0110;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TICK_PERIOD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS  = 1'b1;

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 7'd5;
  localparam logic [COUNT_W-1:0]  LONG_PRESS_RST  = 16'd100;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_CW        = 3'd1;
  localparam logic [EVENT_W-1:0] EV_CCW       = 3'd2;
  localparam logic [EVENT_W-1:0] EV_OK        = 3'd3;
  localparam logic [EVENT_W-1:0] EV_OK_LONG   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_BACK      = 3'd5;
  localparam logic [EVENT_W-1:0] EV_BACK_LONG = 3'd6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_READ = 2'd1,
    ACT_SET  = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV
  } state_t;

  // Acceleration step table
  function automatic logic [STEP_W-1:0] step_rom(input logic [STEP_IDX_W-1:0] idx);
    logic [STEP_W-1:0] v;
    case (idx)
      5'd0:    v = 15'd1;
      5'd1:    v = 15'd1;
      5'd2:    v = 15'd2;
      5'd3:    v = 15'd3;
      5'd4:    v = 15'd4;
      5'd5:    v = 15'd6;
      5'd6:    v = 15'd8;
      5'd7:    v = 15'd11;
      5'd8:    v = 15'd16;
      5'd9:    v = 15'd23;
      5'd10:   v = 15'd32;
      5'd11:   v = 15'd45;
      5'd12:   v = 15'd64;
      5'd13:   v = 15'd91;
      5'd14:   v = 15'd128;
      5'd15:   v = 15'd181;
      5'd16:   v = 15'd256;
      5'd17:   v = 15'd362;
      5'd18:   v = 15'd512;
      5'd19:   v = 15'd724;
      5'd20:   v = 15'd1024;
      5'd21:   v = 15'd1448;
      5'd22:   v = 15'd2048;
      5'd23:   v = 15'd2896;
      5'd24:   v = 15'd4096;
      5'd25:   v = 15'd5793;
      5'd26:   v = 15'd8192;
      5'd27:   v = 15'd11585;
      5'd28:   v = 15'd16384;
      default: v = 15'd23170;
    endcase
    return v;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[rtl/encoder_and_button_event_decoder.sv]
// A read beat's result is loaded into the output register as the beat is accepted.
// Throughput: one beat per cycle for reads, sets and ordinary ticks, while no read is
// held back by an unclaimed result; a tick that completes a detent with nonzero elapsed
// time stalls the input while the 10-step serial divider computes the speed, plus load.
// Reset: synchronous, active high; clears all tracking state, sets speed to 1
// and restores tick_period_ms to 5 and long_press_ticks to 100.
module encoder_and_button_event_decoder import rbd_pkg::*; #(
  parameter int STEP_TABLE_DEPTH = STEP_TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [ACTION_W-1:0]    action,
  input  logic                   rotary_a,
  input  logic                   rotary_b,
  input  logic                   ok_pin,
  input  logic                   back_pin,
  input  logic [EVENT_W-1:0]     set_code,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [EVENT_W-1:0]     event_code,
  output logic [STEP_W-1:0]      step_size,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [STEP_IDX_W-1:0] STEP_IDX_MAX = STEP_IDX_W'(STEP_TABLE_DEPTH - 1);

  state_t state, state_next;

  logic [PERIOD_W-1:0]  tick_period_ms;
  logic [COUNT_W-1:0]   long_press_ticks;
  logic [3:0]           transition_code;
  logic [7:0]           transition_history;
  logic [COUNT_W-1:0]   ticks_since_detent;
  logic [SPEED_W-1:0]   speed_level;
  logic [EVENT_W-1:0]   pending_event;
  logic [1:0]           button_now;
  logic [1:0]           button_last;
  logic [1:0]           press_armed;
  logic [COUNT_W-1:0]   hold_ticks [2];
  logic [ELAPSED_W-1:0] elapsed;

  // Tick next values
  logic [3:0]           transition_code_next;
  logic [7:0]           transition_history_next;
  logic [COUNT_W-1:0]   ticks_inc;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic                 move_ok;
  logic                 detent;
  logic [EVENT_W-1:0]   tick_event;
  logic [1:0]           button_now_next;
  logic [1:0]           press_armed_next;
  logic [COUNT_W-1:0]   hold_ticks_next [2];

  logic                 accept;
  logic                 read_blocked;
  logic                 start_div;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] quotient;
  logic [SPEED_W-1:0]   speed_div;
  logic [STEP_IDX_W-1:0] step_idx;

  assign accept = item_valid && !item_stall;

  // Hold reads while an unclaimed result sits in the output register
  assign read_blocked = result_valid && result_stall && (action == ACT_READ);

  // Encoder and button tracking for one sample tick
  always_comb begin
    transition_code_next    = {transition_code[1:0], rotary_a, rotary_b};
    move_ok                 = VALID_MOVE[transition_code_next];
    transition_history_next = move_ok ? {transition_history[3:0], transition_code_next}
                                      : transition_history;
    ticks_inc    = sat_inc(ticks_since_detent);
    elapsed_next = ELAPSED_W'(ticks_inc) * ELAPSED_W'(tick_period_ms);
    detent       = move_ok && ((transition_history_next == HIST_CW) ||
                               (transition_history_next == HIST_CCW));
    tick_event   = pending_event;
    if (move_ok && (transition_history_next == HIST_CW)) tick_event = EV_CW;
    if (move_ok && (transition_history_next == HIST_CCW)) tick_event = EV_CCW;

    button_now_next  = ~{back_pin, ok_pin};
    press_armed_next = press_armed;
    for (int i = 0; i < 2; i++) begin
      hold_ticks_next[i] = sat_inc(hold_ticks[i]);
      if (button_now_next[i] && !button_now[i]) begin
        hold_ticks_next[i]  = '0;
        press_armed_next[i] = 1'b1;
      end
    end
    // Long press, OK before back
    for (int i = 0; i < 2; i++) begin
      if (button_now_next[i] && button_now[i] && press_armed_next[i] &&
          (hold_ticks_next[i] >= long_press_ticks)) begin
        tick_event          = (i == 0) ? EV_OK_LONG : EV_BACK_LONG;
        press_armed_next[i] = 1'b0;
      end
    end
    // Short press on release
    for (int i = 0; i < 2; i++) begin
      if (!button_now_next[i] && button_now[i] && press_armed_next[i]) begin
        tick_event          = (i == 0) ? EV_OK : EV_BACK;
        press_armed_next[i] = 1'b0;
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (action == ACT_TICK) && detent && (elapsed_next != '0)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    start_div  = 1'b0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: item_stall = read_blocked;
      ST_LOAD: start_div  = 1'b1;
      ST_DIV:  item_stall = 1'b1;
      default: item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  rbd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start_div),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (quotient)
  );

  // Clamp the quotient into the speed range
  assign speed_div = (quotient == '0) ? SPEED_MIN :
                     (quotient > DIV_NUM_W'(SPEED_MAX)) ? SPEED_MAX :
                     quotient[SPEED_W-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_ms   <= TICK_PERIOD_RST;
      long_press_ticks <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_PERIOD: tick_period_ms   <= cfg_data[PERIOD_W-1:0];
        CFG_LONG_PRESS:  long_press_ticks <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Tracking state and pending event
  always_ff @(posedge clk) begin
    if (rst) begin
      transition_code    <= '0;
      transition_history <= '0;
      ticks_since_detent <= '0;
      speed_level        <= SPEED_MIN;
      pending_event      <= EV_NONE;
      button_now         <= '0;
      button_last        <= '0;
      press_armed        <= '0;
      hold_ticks[0]      <= '0;
      hold_ticks[1]      <= '0;
    end else begin
      if (div_done) speed_level <= speed_div;
      if (accept) begin
        case (action)
          ACT_TICK: begin
            transition_code    <= transition_code_next;
            transition_history <= transition_history_next;
            ticks_since_detent <= detent ? '0 : ticks_inc;
            if (detent && (elapsed_next == '0)) speed_level <= SPEED_MAX;
            pending_event      <= tick_event;
            button_last        <= button_now;
            button_now         <= button_now_next;
            press_armed        <= press_armed_next;
            hold_ticks[0]      <= hold_ticks_next[0];
            hold_ticks[1]      <= hold_ticks_next[1];
          end
          ACT_READ: pending_event <= EV_NONE;
          ACT_SET:  if (set_code <= EV_BACK_LONG) pending_event <= set_code;
          default: ;
        endcase
      end
    end
  end

  // Capture the elapsed time for the divider
  always_ff @(posedge clk) begin
    if (accept && (action == ACT_TICK) && detent) elapsed <= elapsed_next;
  end

  // Step table index, clamped to the table depth
  assign step_idx = ((speed_level - 1'b1) > STEP_IDX_MAX) ? STEP_IDX_MAX
                                                          : STEP_IDX_W'(speed_level - 1'b1);

  // Output register: load on a read beat, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && (action == ACT_READ)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (action == ACT_READ)) begin
      event_code <= pending_event;
      step_size  <= step_rom(step_idx);
    end
  end

`ifndef SYNTHESIS
  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && (action == ACT_READ) |=> result_valid)
    else $error("read beat did not load a result");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) || (state == ST_DIV) |-> item_stall)
    else $error("input accepted while speed computation runs");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    (speed_level >= SPEED_MIN) && (speed_level <= SPEED_MAX))
    else $error("speed level out of range");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside its state");
`endif

endmodule

[rtl/rbd_div.sv]
// Serial restoring divider: one quotient bit of DIV_NUM / divisor per cycle.
module rbd_div import rbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ELAPSED_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [ELAPSED_W-1:0] dvsr;
  logic [ELAPSED_W-1:0] rem;
  logic [ELAPSED_W:0]   trial;
  logic                 fits;

  // Shift the next numerator bit into the partial remainder and compare
  assign trial = {rem, quotient[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  // Control: load on start, count down one step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: numerator shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr     <= divisor;
      rem      <= '0;
      quotient <= DIV_NUM;
    end else if (busy) begin
      rem      <= fits ? ELAPSED_W'(trial - {1'b0, dvsr}) : trial[ELAPSED_W-1:0];
      quotient <= {quotient[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

[test/encoder_and_button_event_decoder_tb.sv]
// Self-checking testbench for the rotary encoder and button event decoder.
module encoder_and_button_event_decoder_tb import rbd_pkg::*; ();

  localparam int QUIET_LIMIT    = 2000;  // cycles with no accepted beat before giving up
  localparam int SETTLE_CYCLES  = 16;    // covers the serial speed divider after a detent
  localparam int RX_HOLD_CYCLES = 200;
  localparam int STEP_LAST      = 29;    // last usable step table entry
  localparam int PHASE_ITEMS    = 160;

  typedef struct packed {
    logic [EVENT_W-1:0] ev;
    logic [STEP_W-1:0]  step;
  } readout_t;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  logic [ACTION_W-1:0]    action;
  logic                   rotary_a;
  logic                   rotary_b;
  logic                   ok_pin;
  logic                   back_pin;
  logic [EVENT_W-1:0]     set_code;
  logic                   result_valid;
  logic                   result_stall;
  logic [EVENT_W-1:0]     event_code;
  logic [STEP_W-1:0]      step_size;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Acceleration steps indexed by speed minus one
  logic [STEP_W-1:0] accel_steps [32] = '{
    15'd1, 15'd1, 15'd2, 15'd3, 15'd4, 15'd6, 15'd8, 15'd11,
    15'd16, 15'd23, 15'd32, 15'd45, 15'd64, 15'd91, 15'd128, 15'd181,
    15'd256, 15'd362, 15'd512, 15'd724, 15'd1024, 15'd1448, 15'd2048, 15'd2896,
    15'd4096, 15'd5793, 15'd8192, 15'd11585, 15'd16384, 15'd23170, 15'd23170, 15'd23170
  };

  // Predicted decoder state
  bit [PERIOD_W-1:0]  cfg_period;
  bit [COUNT_W-1:0]   cfg_long;
  bit [3:0]           pin_pair_code;
  bit [7:0]           move_history;
  bit [COUNT_W-1:0]   ticks_since_turn;
  bit [SPEED_W-1:0]   speed_now;
  bit [EVENT_W-1:0]   event_pending;
  bit                 btn_now  [2];
  bit                 btn_prev [2];
  bit                 btn_armed[2];
  bit [COUNT_W-1:0]   btn_hold [2];

  readout_t readout_q[$];

  // Stimulus-side state
  bit enc_a, enc_b;
  bit ok_lvl, back_lvl;
  bit sender_idling, rx_idling, rx_hold_req;
  int errors, beats_sent, reads_checked, quiet_cycles;

  encoder_and_button_event_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .rotary_a     (rotary_a),
    .rotary_b     (rotary_b),
    .ok_pin       (ok_pin),
    .back_pin     (back_pin),
    .set_code     (set_code),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .event_code   (event_code),
    .step_size    (step_size),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bit [COUNT_W-1:0] bump16(input bit [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  task automatic reset_decoder_model();
    cfg_period       = TICK_PERIOD_RST;
    cfg_long         = LONG_PRESS_RST;
    pin_pair_code    = '0;
    move_history     = '0;
    ticks_since_turn = '0;
    speed_now        = SPEED_MIN;
    event_pending    = EV_NONE;
    for (int i = 0; i < 2; i++) begin
      btn_now[i]   = 1'b0;
      btn_prev[i]  = 1'b0;
      btn_armed[i] = 1'b0;
      btn_hold[i]  = '0;
    end
  endtask

  // Advance the predicted state by one accepted beat; queue the readout of a read
  task automatic decode_beat(input action_t act, input bit a, input bit b, input bit okp,
                             input bit bkp, input logic [EVENT_W-1:0] code);
    readout_t  r;
    bit        level[2];
    bit [31:0] elapsed;
    bit [31:0] spd;
    int        idx;
    case (act)
      ACT_TICK: begin
        ticks_since_turn = bump16(ticks_since_turn);
        pin_pair_code = {pin_pair_code[1:0], a, b};
        if (VALID_MOVE[pin_pair_code]) begin
          move_history = {move_history[3:0], pin_pair_code};
          if (move_history == HIST_CW || move_history == HIST_CCW) begin
            event_pending = (move_history == HIST_CW) ? EV_CW : EV_CCW;
            elapsed = ticks_since_turn * cfg_period;
            spd = (elapsed == 0) ? 32'd30 : 32'd1000 / elapsed;
            if (spd < 1) spd = 1;
            if (spd > 30) spd = 30;
            speed_now = spd[SPEED_W-1:0];
            ticks_since_turn = '0;
          end
        end
        level[0] = okp;
        level[1] = bkp;
        for (int i = 0; i < 2; i++) begin
          btn_prev[i] = btn_now[i];
          btn_now[i]  = !level[i];
          btn_hold[i] = bump16(btn_hold[i]);
          if (btn_now[i] && !btn_prev[i]) begin
            btn_hold[i]  = '0;
            btn_armed[i] = 1'b1;
          end
        end
        // long presses first, then releases, so a later write wins
        for (int i = 0; i < 2; i++) begin
          if (btn_now[i] && btn_prev[i] && btn_armed[i] && btn_hold[i] >= cfg_long) begin
            event_pending = (i == 0) ? EV_OK_LONG : EV_BACK_LONG;
            btn_armed[i]  = 1'b0;
          end
        end
        for (int i = 0; i < 2; i++) begin
          if (!btn_now[i] && btn_prev[i] && btn_armed[i]) begin
            event_pending = (i == 0) ? EV_OK : EV_BACK;
            btn_armed[i]  = 1'b0;
          end
        end
      end
      ACT_READ: begin
        idx = int'(speed_now) - 1;
        if (idx < 0) idx = 0;
        if (idx > STEP_LAST) idx = STEP_LAST;
        r.ev   = event_pending;
        r.step = accel_steps[idx];
        readout_q.push_back(r);
        event_pending = EV_NONE;
      end
      ACT_SET: begin
        if (code <= EV_BACK_LONG) event_pending = code;
      end
      default: ;
    endcase
  endtask

  // Offer one beat, with an optional idle burst first, and hold it until accepted
  task automatic send_beat(input action_t act, input bit a, input bit b, input bit okp,
                           input bit bkp, input logic [EVENT_W-1:0] code);
    int gap;
    @(negedge clk);
    if (sender_idling && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    rotary_a   <= a;
    rotary_b   <= b;
    ok_pin     <= okp;
    back_pin   <= bkp;
    set_code   <= code;
    do @(posedge clk); while (item_stall);
    beats_sent++;
    decode_beat(act, a, b, okp, bkp, code);
  endtask

  task automatic release_input();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic tick_pins(input bit a, input bit b);
    enc_a = a;
    enc_b = b;
    send_beat(ACT_TICK, a, b, ok_lvl, back_lvl, EVENT_W'($urandom_range(0, 7)));
  endtask

  // Move the encoder one Gray step
  task automatic turn(input bit cw);
    if (cw) tick_pins(!enc_b, enc_a);
    else tick_pins(enc_b, !enc_a);
  endtask

  task automatic read_event();
    send_beat(ACT_READ, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              EVENT_W'($urandom_range(0, 7)));
  endtask

  task automatic set_event(input logic [EVENT_W-1:0] code);
    send_beat(ACT_SET, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), code);
  endtask

  // Write a register once every readout is back and the divider has settled
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    release_input();
    wait (readout_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    if (idx == CFG_TICK_PERIOD)
      cfg_data <= {9'($urandom), val[PERIOD_W-1:0]};
    else
      cfg_data <= val[COUNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TICK_PERIOD) cfg_period = val[PERIOD_W-1:0];
    else cfg_long = val[COUNT_W-1:0];
  endtask

  // Readout path with no events, sets including the ignored code, and the unused action
  task automatic test_event_register();
    read_event();
    set_event(EV_BACK_LONG);
    set_event(3'd7);
    send_beat(ACT_NOP, 1'b1, 1'b1, 1'b0, 1'b0, 3'd5);
    read_event();
    set_event(EV_NONE);
    read_event();
  endtask

  // One clockwise and one counter-clockwise detent
  task automatic test_detents();
    turn(1'b1);
    turn(1'b1);
    read_event();
    repeat (4) turn(1'b0);
    read_event();
  endtask

  // Long and short presses, and two releases on the same tick
  task automatic test_buttons();
    write_reg(CFG_LONG_PRESS, 1);
    ok_lvl = 1'b0;
    tick_pins(enc_a, enc_b);
    tick_pins(enc_a, enc_b);
    read_event();
    ok_lvl = 1'b1;
    tick_pins(enc_a, enc_b);
    back_lvl = 1'b0;
    tick_pins(enc_a, enc_b);
    back_lvl = 1'b1;
    tick_pins(enc_a, enc_b);
    read_event();
    ok_lvl   = 1'b0;
    back_lvl = 1'b0;
    tick_pins(enc_a, enc_b);
    ok_lvl   = 1'b1;
    back_lvl = 1'b1;
    tick_pins(enc_a, enc_b);
    read_event();
  endtask

  // Zero elapsed time gives full speed; a slow turn clamps to the lowest speed
  task automatic test_speed_clamps();
    write_reg(CFG_TICK_PERIOD, 0);
    repeat (4) turn(1'b1);
    read_event();
    write_reg(CFG_TICK_PERIOD, 100);
    repeat (12) tick_pins(enc_a, enc_b);
    repeat (4) turn(1'b1);
    read_event();
  endtask

  // Mostly Gray-code turning with random button presses, plus reads, sets and noise
  task automatic run_random(input int n);
    bit cw;
    bit down[2];
    int left[2];
    int counted, r, lim;
    cw = 1'b1;
    down[0] = 1'b0;
    down[1] = 1'b0;
    left[0] = 3;
    left[1] = 5;
    counted = 0;
    while (counted < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        for (int i = 0; i < 2; i++) begin
          if (left[i] == 0) begin
            down[i] = !down[i];
            lim = (cfg_long < 30) ? int'(cfg_long) + 3 : 20;
            left[i] = down[i] ? $urandom_range(1, lim) : $urandom_range(1, 8);
          end
          left[i]--;
        end
        ok_lvl   = !down[0];
        back_lvl = !down[1];
        r = $urandom_range(0, 99);
        if (r < 8) cw = !cw;
        if (r < 80) turn(cw);
        else if (r < 92) tick_pins(enc_a, enc_b);
        else tick_pins(1'($urandom), 1'($urandom));
        counted++;
      end else if (r < 88) begin
        read_event();
        counted++;
      end else if (r < 96) begin
        set_event(EVENT_W'($urandom_range(0, 7)));
        if (set_code != 3'd7) counted++;
      end else begin
        send_beat(ACT_NOP, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  EVENT_W'($urandom_range(0, 7)));
      end
    end
  endtask

  // Receiver holds off while reads keep coming, so the input backs up
  task automatic test_receiver_hold();
    sender_idling = 1'b0;
    rx_hold_req   = 1'b1;
    repeat (40) read_event();
    sender_idling = 1'b1;
  endtask

  // Sender stops until every readout has drained, then resumes
  task automatic test_sender_drain();
    repeat (8) read_event();
    release_input();
    wait (readout_q.size() == 0);
    run_random(20);
  endtask

  task automatic test_random_phases();
    int unsigned periods[6] = '{1, 100, 7, 33, 2, 50};
    int unsigned holds[6]   = '{1, 65535, 4, 12, 30, 2};
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_TICK_PERIOD, periods[p]);
      write_reg(CFG_LONG_PRESS, holds[p]);
      if (p == 5) begin
        sender_idling = 1'b0;
        rx_idling     = 1'b0;
      end
      run_random(PHASE_ITEMS);
      if (p == 1) test_receiver_hold();
      if (p == 2) test_sender_drain();
    end
  endtask

  // Drive the result stall: long hold on request, random bursts otherwise
  initial begin : rx_pacing
    int burst, hold_left;
    result_stall = 1'b0;
    burst = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (rx_hold_req) begin
        result_stall <= 1'b1;
        hold_left = RX_HOLD_CYCLES - 1;
        rx_hold_req = 1'b0;
      end else if (burst > 0) begin
        result_stall <= 1'b1;
        burst--;
      end else if (rx_idling && $urandom_range(0, 9) == 0) begin
        result_stall <= 1'b1;
        burst = $urandom_range(0, 11);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted readout with the oldest prediction
  always @(posedge clk) begin
    readout_t want;
    if (!rst && result_valid && !result_stall) begin
      reads_checked++;
      if (readout_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected readout event %0d step %0d", $time, event_code, step_size);
      end else begin
        want = readout_q.pop_front();
        if (event_code !== want.ev) begin
          errors++;
          $display("%0t: event_code expected %0d actual %0d", $time, want.ev, event_code);
        end
        if (step_size !== want.step) begin
          errors++;
          $display("%0t: step_size expected %0d actual %0d", $time, want.step, step_size);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles, %0d readouts outstanding",
               $time, QUIET_LIMIT, readout_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    item_valid    = 1'b0;
    action        = ACT_TICK;
    rotary_a      = 1'b0;
    rotary_b      = 1'b0;
    ok_pin        = 1'b1;
    back_pin      = 1'b1;
    set_code      = EV_NONE;
    cfg_we        = 1'b0;
    cfg_index     = CFG_TICK_PERIOD;
    cfg_data      = '0;
    enc_a         = 1'b0;
    enc_b         = 1'b0;
    ok_lvl        = 1'b1;
    back_lvl      = 1'b1;
    sender_idling = 1'b1;
    rx_idling     = 1'b1;
    rx_hold_req   = 1'b0;
    errors        = 0;
    beats_sent    = 0;
    reads_checked = 0;
    quiet_cycles  = 0;
    reset_decoder_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_event_register();
    test_detents();
    test_buttons();
    test_speed_clamps();
    test_random_phases();

    release_input();
    wait (readout_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d beats and %0d readouts: detents at tick periods 0 to 100,",
             beats_sent, reads_checked);
    $display("long press 1 to 65535, event sets, a long receiver hold and a sender drain.");
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
rtl/rbd_pkg.sv
rtl/rbd_div.sv
rtl/encoder_and_button_event_decoder.sv
test/encoder_and_button_event_decoder_tb.sv
